// ===== rtl/oets_pkg.sv =====
// ============================================================================
// oets_pkg
// Shared constants and command types of the odd-even transposition sorter.
// ============================================================================
package oets_pkg;

  // Capacity of the value buffer.
  localparam int MAX_ITEMS = 64;
  // Width of one value.
  localparam int DATA_W    = 32;
  // Count of held values, 0 to MAX_ITEMS inclusive.
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  // Index of one buffer entry.
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  // Phase counter, two phases per round and up to MAX_ITEMS rounds.
  localparam int PH_W      = CNT_W + 1;

  // Command from the controller to the datapath, one per cycle.
  typedef struct packed {
    logic             load;      // write value_in into entry count
    logic             exchange;  // run one compare-exchange phase
    logic             odd_phase; // 1: pairs (0,1),(2,3)...  0: pairs (1,2),(3,4)...
    logic             shift;     // move every entry down by one place
    logic [CNT_W-1:0] count;     // number of values held
  } dp_cmd_t;

endpackage

// ===== rtl/oets_datapath.sv =====
// ============================================================================
// oets_datapath
// Row of value cells with neighbor compare-exchange, load and shift-out.
// ============================================================================
module oets_datapath (
  input  logic                                clk,
  input  oets_pkg::dp_cmd_t                   cmd,
  input  logic signed [oets_pkg::DATA_W-1:0]  value_in,
  output logic signed [oets_pkg::DATA_W-1:0]  value_out
);

  logic signed [oets_pkg::DATA_W-1:0] row      [oets_pkg::MAX_ITEMS];
  logic signed [oets_pkg::DATA_W-1:0] row_next [oets_pkg::MAX_ITEMS];

  // Each phase touches disjoint pairs, so all exchanges of a phase are
  // computed from the current row in parallel.
  always_comb begin
    row_next = row;
    if (cmd.load) begin
      row_next[cmd.count[oets_pkg::IDX_W-1:0]] = value_in;
    end else if (cmd.exchange) begin
      for (int k = 1; k < oets_pkg::MAX_ITEMS; k++) begin
        if ((k[0] == cmd.odd_phase) && (oets_pkg::CNT_W'(k) < cmd.count)) begin
          if (row[k] < row[k-1]) begin
            row_next[k-1] = row[k];
            row_next[k]   = row[k-1];
          end
        end
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < oets_pkg::MAX_ITEMS - 1; i++) begin
        row_next[i] = row[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
  end

  assign value_out = row[0];

endmodule

// ===== rtl/oets_ctrl.sv =====
// ============================================================================
// oets_ctrl
// Controller: load, sort-phase and emit sequencing of the sorter.
// ============================================================================
module oets_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    last_in,
  output logic                    busy,
  output logic                    done,
  output logic                    last_out,
  output oets_pkg::dp_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t                       state;
  logic [oets_pkg::CNT_W-1:0]   count;
  logic [oets_pkg::PH_W-1:0]    phase;
  logic                         accept;
  logic                         room;
  logic                         phase_end;

  assign accept    = start && (state == ST_LOAD);
  assign room      = count < oets_pkg::CNT_W'(oets_pkg::MAX_ITEMS);
  assign phase_end = phase == ({count, 1'b0} - oets_pkg::PH_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      phase <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + oets_pkg::CNT_W'(1);
            end
            if (last_in) begin
              state <= ST_SORT;
              phase <= '0;
            end
          end
        end
        ST_SORT: begin
          phase <= phase + oets_pkg::PH_W'(1);
          if (phase_end) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          count <= count - oets_pkg::CNT_W'(1);
          if (count == oets_pkg::CNT_W'(1)) begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.count     = count;
    cmd.load      = accept && room;
    cmd.exchange  = state == ST_SORT;
    cmd.odd_phase = ~phase[0];
    cmd.shift     = state == ST_EMIT;
  end

  assign busy     = state != ST_LOAD;
  assign done     = state == ST_EMIT;
  assign last_out = done && (count == oets_pkg::CNT_W'(1));

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= oets_pkg::CNT_W'(oets_pkg::MAX_ITEMS))
    else $error("held count exceeds buffer capacity");

  a_sort_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT) |-> (count != '0))
    else $error("sort started on an empty set");

  a_last_releases: assert property (@(posedge clk) disable iff (rst)
    (done && last_out) |=> (!busy && (count == '0)))
    else $error("block did not return to loading after final result");

  a_emit_follows_sort: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SORT) && phase_end) |=> done)
    else $error("emission did not follow the final sort phase");
`endif

endmodule

// ===== rtl/odd_even_transposition_sorter_top.sv =====
// ============================================================================
// odd_even_transposition_sorter_top
// Odd-even transposition sorter for sets of up to MAX_ITEMS signed values.
// ============================================================================
// Usage:
//   Input transactions are taken at a rising edge where start is high and
//   busy is low, one value_in per transaction. The transaction with last_in
//   set closes the set and starts the sort. Values arriving while the
//   buffer is full are dropped; a dropped value that carries last_in still
//   closes the set.
//   Sorting runs one round per held value n, each round an odd and an even
//   compare-exchange phase over the held values, all pairs of a phase at
//   once. After the final phase the results follow, one result per cycle,
//   in ascending signed order, each marked by done for exactly one cycle;
//   last_out flags the largest. busy stays high from the closing edge until
//   the final result.
//   The receiver cannot stall: every done cycle is a completed transaction.
//   Reset (rst, synchronous) empties the buffer and returns to loading.
// ============================================================================
module odd_even_transposition_sorter_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [oets_pkg::DATA_W-1:0] value_in,
  input  logic                               last_in,
  output logic                               done,
  output logic signed [oets_pkg::DATA_W-1:0] value_out,
  output logic                               last_out
);

  // Per-cycle command from the controller to the cell row.
  oets_pkg::dp_cmd_t cmd;

  // The controller tracks the held count and sequences load, the 2n sort
  // phases and emission.
  oets_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .last_in  (last_in),
    .busy     (busy),
    .done     (done),
    .last_out (last_out),
    .cmd      (cmd)
  );

  // The datapath holds the values; during emission the row shifts down and
  // entry zero drives value_out.
  oets_datapath u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .value_in  (value_in),
    .value_out (value_out)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the odd-even transposition sorter against its own sort prediction.
// ============================================================================
// Sets of signed values go in as start/busy transactions. Each set is closed
// by the value that carries last_in. For every accepted transaction the bench
// updates its own copy of the held set. When a set closes, it sorts the set
// and queues the ascending results. Every done cycle is compared with the
// oldest queued result. A directed opening covers single values, the signed
// extremes, equal values and reversed order. Random sets follow, including a
// set that fills the buffer exactly and one whose extra values and closing
// value are dropped.
// ============================================================================
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 260;
  localparam int QUIET_TAIL   = 40;

  localparam logic signed [oets_pkg::DATA_W-1:0] MOST_NEG =
    {1'b1, {(oets_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [oets_pkg::DATA_W-1:0] MOST_POS =
    {1'b0, {(oets_pkg::DATA_W-1){1'b1}}};

  // One input transaction: a value and the flag that closes its set.
  typedef struct {
    logic signed [oets_pkg::DATA_W-1:0] value;
    logic                               last;
  } set_item_t;

  // One result transaction of a sorted run.
  typedef struct {
    logic signed [oets_pkg::DATA_W-1:0] value;
    logic                               last;
  } sorted_item_t;

  logic                               clk      = 1'b0;
  logic                               rst      = 1'b1;
  logic                               start    = 1'b0;
  logic signed [oets_pkg::DATA_W-1:0] value_in = '0;
  logic                               last_in  = 1'b0;
  logic                               busy;
  logic                               done;
  logic signed [oets_pkg::DATA_W-1:0] value_out;
  logic                               last_out;

  // Transactions waiting to be driven, filled by the stimulus process.
  set_item_t                          pending_items[$];
  // Values the sorter holds at this moment, as far as the bench can tell.
  logic signed [oets_pkg::DATA_W-1:0] held_values[$];
  // Sorted values still to come out of the block, oldest first.
  sorted_item_t                       sorted_results[$];

  logic item_taken = 1'b0;
  int   gap_left   = 0;
  int   cycle_count = 0;
  int   failures    = 0;

  odd_even_transposition_sorter_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value_in  (value_in),
    .last_in   (last_in),
    .done      (done),
    .value_out (value_out),
    .last_out  (last_out)
  );

  always #5 clk = ~clk;

  // The first few failures are shown in full; after that they are only counted.
  task automatic note_failure(string msg);
    if (failures < REPORT_LIMIT) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    failures++;
  endtask

  // Prediction for one accepted transaction. A value is kept only while the
  // buffer has room, which is exactly the saturation the block applies. The
  // closing transaction sorts what is held in ascending signed order, flags
  // the largest one and empties the buffer for the next set.
  task automatic absorb_value(logic signed [oets_pkg::DATA_W-1:0] value, logic last);
    logic signed [oets_pkg::DATA_W-1:0] ordered[$];
    logic signed [oets_pkg::DATA_W-1:0] key;
    sorted_item_t                       res;
    int                                 j;
    if (held_values.size() < oets_pkg::MAX_ITEMS) begin
      held_values.push_back(value);
    end
    if (last) begin
      // Plain insertion sort; equal values cannot be told apart afterwards,
      // so the order among them does not matter.
      ordered = held_values;
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      foreach (ordered[i]) begin
        res.value = ordered[i];
        res.last  = (i == ordered.size() - 1);
        sorted_results.push_back(res);
      end
      held_values.delete();
    end
  endtask

  task automatic queue_value(logic signed [oets_pkg::DATA_W-1:0] value, logic last);
    set_item_t itm;
    itm.value = value;
    itm.last  = last;
    pending_items.push_back(itm);
  endtask

  // Mixes the signed extremes, a narrow band around zero that makes equal
  // values common, and full 32-bit random patterns so every bit toggles.
  function automatic logic signed [oets_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7)) inside
      0:       return MOST_NEG;
      1:       return MOST_POS;
      [2:3]:   return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Queues one set of n values; only the final one carries last_in. With n
  // above the buffer size the trailing values, the closing one included,
  // are the ones the block drops.
  task automatic queue_set(int n);
    for (int i = 0; i < n; i++) begin
      queue_value(pick_value(), i == n - 1);
    end
  endtask

  // Driver. A new transaction goes out at the falling edge once the previous
  // one was taken. start stays high across busy until the block accepts, so
  // values wait through whole sort and emit phases. Bursts of idle cycles are
  // inserted after some transactions, except near the end of the run.
  always @(negedge clk) begin
    set_item_t itm;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        itm      = pending_items.pop_front();
        value_in <= itm.value;
        last_in  <= itm.last;
        start    <= 1'b1;
        if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(1, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. At the rising edge it records accepted input transactions for
  // the prediction and checks every done cycle against the oldest expected
  // result. It also enforces the overall cycle limit.
  always @(posedge clk) begin
    sorted_item_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;
      if (start && !busy) begin
        absorb_value(value_in, last_in);
      end
      if (done) begin
        if (sorted_results.size() == 0) begin
          note_failure($sformatf("result with none expected: value %0d last %0b",
                                 value_out, last_out));
        end else begin
          want = sorted_results.pop_front();
          if (value_out !== want.value || last_out !== want.last) begin
            note_failure($sformatf("expected value %0d last %0b, got value %0d last %0b",
                                   want.value, want.last, value_out, last_out));
          end
        end
      end
    end
  end

  initial begin
    int random_count;
    int set_no;
    int n;

    // Directed opening: single values at both extremes, a pair in reverse
    // order, equal values, and a short set out of order with both extremes.
    queue_value(MOST_NEG, 1'b1);
    queue_value(MOST_POS, 1'b1);
    queue_value(MOST_POS, 1'b0);
    queue_value(MOST_NEG, 1'b1);
    queue_value(0, 1'b0);
    queue_value(-1, 1'b0);
    queue_value(0, 1'b1);
    queue_value(-1, 1'b0);
    queue_value(-1, 1'b1);
    queue_value(MOST_POS, 1'b0);
    queue_value(7, 1'b0);
    queue_value(-7, 1'b0);
    queue_value(MOST_NEG, 1'b0);
    queue_value(0, 1'b1);

    // Random sets, mostly short. One set fills the buffer exactly, and one
    // overruns it so that its closing value is dropped but still ends the set.
    random_count = 0;
    set_no = 0;
    while (random_count < RANDOM_ITEMS) begin
      if (set_no == 4) begin
        n = oets_pkg::MAX_ITEMS;
      end else if (set_no == 10) begin
        n = oets_pkg::MAX_ITEMS + $urandom_range(1, 3);
      end else if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(13, 30);
      end else begin
        n = $urandom_range(1, 12);
      end
      queue_set(n);
      random_count += (n > oets_pkg::MAX_ITEMS) ? oets_pkg::MAX_ITEMS : n;
      set_no++;
    end

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Wait until every transaction is accepted and every result has come out,
    // then give the block time to show any result it should not produce.
    while (!(pending_items.size() == 0 && !start)) @(negedge clk);
    while (sorted_results.size() != 0) @(negedge clk);
    repeat (4 * oets_pkg::MAX_ITEMS) @(posedge clk);

    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
